[rtl/core/tsm_pkg.sv]
// types, codes and defaults shared by the typed stack machine core
`timescale 1ns / 1ps
`default_nettype none
package tsm_pkg;

    localparam int STACK_DEPTH_D   = 256;
    localparam int LOGIC_DEPTH_D   = 64;
    localparam int MAX_CHAIN_D     = 8;
    localparam int PRIMITIVE_COUNT = 25;
    localparam int COND_FIRST      = 20;
    localparam int COND_END        = 23;

    typedef struct packed {
        logic [1:0]         symbol_tag;
        logic signed [31:0] symbol_value;
    } t_in_item;

    typedef struct packed {
        logic [3:0]         status;
        logic [4:0]         executed_op;
        logic               emit_char_valid;
        logic [7:0]         emit_char;
        logic               show_valid;
        logic signed [31:0] top_value;
        logic [1:0]         top_tag;
        logic [8:0]         stack_depth;
        logic [1:0]         logic_state;
        logic               last;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_OK         = 4'd0,
        ST_SKIP       = 4'd1,
        ST_TYPE       = 4'd2,
        ST_DIVZ       = 4'd3,
        ST_FRAME      = 4'd4,
        ST_LOGIC      = 4'd5,
        ST_INVALID    = 4'd6,
        ST_OVFL       = 4'd7,
        ST_CHAIN      = 4'd8,
        ST_LOGIC_FULL = 4'd9
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_STEP, S_RD1, S_RD2, S_EXEC, S_DIV, S_DIVW,
        S_GETW, S_REFILL, S_LOADTOP, S_LLOAD, S_EMIT
    } t_state;

    // input symbol tags
    localparam logic [1:0] IN_WORD  = 2'd0;
    localparam logic [1:0] IN_INT   = 2'd1;
    localparam logic [1:0] IN_QWORD = 2'd2;
    localparam logic [1:0] IN_QLIT  = 2'd3;

    // stack entry tags
    localparam logic [1:0] ENT_WORD  = 2'd0;
    localparam logic [1:0] ENT_INT   = 2'd1;
    localparam logic [1:0] ENT_LIT   = 2'd2;
    localparam logic [1:0] ENT_EMPTY = 2'd3;

    // conditional states
    localparam logic [1:0] LS_NONE   = 2'd0;
    localparam logic [1:0] LS_TAKEN  = 2'd1;
    localparam logic [1:0] LS_SKIP   = 2'd2;
    localparam logic [1:0] LS_NESTED = 2'd3;

    // primitive ids
    localparam logic [4:0] OP_ADD   = 5'd0;
    localparam logic [4:0] OP_SUB   = 5'd1;
    localparam logic [4:0] OP_MUL   = 5'd2;
    localparam logic [4:0] OP_DIV   = 5'd3;
    localparam logic [4:0] OP_MOD   = 5'd4;
    localparam logic [4:0] OP_AND   = 5'd5;
    localparam logic [4:0] OP_OR    = 5'd6;
    localparam logic [4:0] OP_XOR   = 5'd7;
    localparam logic [4:0] OP_NOT   = 5'd8;
    localparam logic [4:0] OP_GET   = 5'd9;
    localparam logic [4:0] OP_SET   = 5'd10;
    localparam logic [4:0] OP_POP   = 5'd11;
    localparam logic [4:0] OP_PRINT = 5'd12;
    localparam logic [4:0] OP_SHOW  = 5'd13;
    localparam logic [4:0] OP_LT    = 5'd14;
    localparam logic [4:0] OP_LE    = 5'd15;
    localparam logic [4:0] OP_EQ    = 5'd16;
    localparam logic [4:0] OP_GE    = 5'd17;
    localparam logic [4:0] OP_GT    = 5'd18;
    localparam logic [4:0] OP_NE    = 5'd19;
    localparam logic [4:0] OP_IF    = 5'd20;
    localparam logic [4:0] OP_ELSE  = 5'd21;
    localparam logic [4:0] OP_THEN  = 5'd22;
    localparam logic [4:0] OP_EXEC  = 5'd23;
    localparam logic [4:0] OP_NIL   = 5'd24;
    localparam logic [4:0] OP_NONE  = 5'd31;

endpackage
`default_nettype wire

[rtl/core/tsm_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module tsm_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

[rtl/core/typed_stack_machine_core_unit.sv]
// typed stack machine core: sequencer around the data stack and conditional stack rams
// an item is accepted in idle (push, skip or overflow); a primitive step runs step,
// two reads, exec, emit; division and modulo add the divider (one quotient bit a cycle)
// a chain of up to MAX_CHAIN steps runs one step at a time through the single read port
// each result waits in the output register; the next item is taken after the last result
// reset clears the stack pointer, the conditional pointer (one entry) and the output valid
// the rams need no clearing pass: no entry is used before it is written
`timescale 1ns / 1ps
`default_nettype none
module typed_stack_machine_core_unit #(
    parameter int STACK_DEPTH = tsm_pkg::STACK_DEPTH_D,
    parameter int LOGIC_DEPTH = tsm_pkg::LOGIC_DEPTH_D,
    parameter int MAX_CHAIN   = tsm_pkg::MAX_CHAIN_D
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire tsm_pkg::t_in_item  i_in_data,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output tsm_pkg::t_out_item      o_out_data,
    input  wire logic               i_out_stall
);
    import tsm_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int LAW = $clog2(LOGIC_DEPTH);
    localparam int LPW = $clog2(LOGIC_DEPTH + 1);
    localparam int NW  = $clog2(MAX_CHAIN + 1);

    t_state             r_state, n_state;
    logic [SPW-1:0]     r_sp, n_sp;
    logic signed [31:0] r_tv, n_tv;
    logic [1:0]         r_tt, n_tt;
    logic [LPW-1:0]     r_lp, n_lp;
    logic [1:0]         r_ltop, n_ltop;
    logic [NW-1:0]      r_n, n_n;
    logic [4:0]         r_id, n_id;
    logic [33:0]        r_t, n_t;
    logic [33:0]        r_s, n_s;
    t_status            r_st, n_st;
    logic [4:0]         r_op, n_op;
    logic               r_ev, n_ev;
    logic [7:0]         r_ec, n_ec;
    logic               r_sv, n_sv;
    logic               r_final, n_final;
    logic [31:0]        r_dq, n_dq;
    logic [32:0]        r_dr, n_dr;
    logic [31:0]        r_dd, n_dd;
    logic [4:0]         r_dcnt, n_dcnt;
    logic               r_dnq, n_dnq;
    logic               r_dnr, n_dnr;
    logic               r_ov, n_ov;
    t_out_item          r_out, n_out;

    logic               s_we;
    logic [AW-1:0]      s_waddr, s_raddr;
    logic [33:0]        s_wdata, s_rdata;
    logic               l_we;
    logic [LAW-1:0]     l_waddr, l_raddr;
    logic [1:0]         l_wdata, l_rdata;

    logic [SPW-1:0]     sp_m1, sp_m2;
    logic [31:0]        t_val, s_val, mul_lo, bin_res, div_res;
    logic [1:0]         t_tag, s_tag;
    logic               two_int, top_int, cont, at_limit, out_free, emit_last, in_skip;
    logic [33:0]        get_idx, set_idx, t_ext;
    logic [32:0]        rem_sh, rem_diff;
    logic [1:0]         push_tag;

    tsm_ram #(.WIDTH(34), .DEPTH(STACK_DEPTH)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_waddr),
        .i_wdata (s_wdata),
        .i_raddr (s_raddr),
        .o_rdata (s_rdata)
    );

    tsm_ram #(.WIDTH(2), .DEPTH(LOGIC_DEPTH)) u_logic_ram (
        .i_clk   (i_clk),
        .i_we    (l_we),
        .i_waddr (l_waddr),
        .i_wdata (l_wdata),
        .i_raddr (l_raddr),
        .o_rdata (l_rdata)
    );

    assign sp_m1   = r_sp - SPW'(1);
    assign sp_m2   = r_sp - SPW'(2);
    assign t_val   = r_t[31:0];
    assign t_tag   = r_t[33:32];
    assign s_val   = r_s[31:0];
    assign s_tag   = r_s[33:32];
    assign two_int = (r_sp >= SPW'(2)) && (t_tag == ENT_INT) && (s_tag == ENT_INT);
    assign top_int = (r_sp != '0) && (t_tag == ENT_INT);
    assign mul_lo  = s_val * t_val;
    assign t_ext   = {{2{t_val[31]}}, t_val};
    assign get_idx = 34'(r_sp) - 34'd2 - t_ext;
    assign set_idx = 34'(r_sp) - 34'd3 - t_ext;
    assign rem_sh  = {r_dr[31:0], r_dq[31]};
    assign rem_diff = rem_sh - {1'b0, r_dd};
    assign div_res = (r_id == OP_DIV) ? (r_dnq ? -r_dq : r_dq)
                                      : (r_dnr ? -r_dr[31:0] : r_dr[31:0]);

    // another primitive waiting on top after a step
    assign cont     = (r_sp != '0) && (r_tt == ENT_WORD) && (r_tv < PRIMITIVE_COUNT);
    assign at_limit = r_n >= NW'(MAX_CHAIN);
    assign out_free = !r_ov || !i_out_stall;
    assign emit_last = r_final || !cont || at_limit;

    assign in_skip = ((r_ltop == LS_SKIP) || (r_ltop == LS_NESTED)) &&
                     !((i_in_data.symbol_tag == IN_WORD) &&
                       ($signed(i_in_data.symbol_value) >= COND_FIRST) &&
                       ($signed(i_in_data.symbol_value) < COND_END));
    assign push_tag = (i_in_data.symbol_tag == IN_INT)  ? ENT_INT :
                      (i_in_data.symbol_tag == IN_QLIT) ? ENT_LIT : ENT_WORD;

    always_comb begin
        case (r_id)
            OP_ADD:  bin_res = s_val + t_val;
            OP_SUB:  bin_res = s_val - t_val;
            OP_MUL:  bin_res = mul_lo;
            OP_AND:  bin_res = s_val & t_val;
            OP_OR:   bin_res = s_val | t_val;
            OP_XOR:  bin_res = s_val ^ t_val;
            OP_LT:   bin_res = {31'd0, $signed(s_val) <  $signed(t_val)};
            OP_LE:   bin_res = {31'd0, $signed(s_val) <= $signed(t_val)};
            OP_GE:   bin_res = {31'd0, $signed(s_val) >= $signed(t_val)};
            OP_GT:   bin_res = {31'd0, $signed(s_val) >  $signed(t_val)};
            OP_EQ:   bin_res = {31'd0, r_s == r_t};
            OP_NE:   bin_res = {31'd0, r_s != r_t};
            default: bin_res = '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_sp    = r_sp;
        n_tv    = r_tv;
        n_tt    = r_tt;
        n_lp    = r_lp;
        n_ltop  = r_ltop;
        n_n     = r_n;
        n_id    = r_id;
        n_t     = r_t;
        n_s     = r_s;
        n_st    = r_st;
        n_op    = r_op;
        n_ev    = r_ev;
        n_ec    = r_ec;
        n_sv    = r_sv;
        n_final = r_final;
        n_dq    = r_dq;
        n_dr    = r_dr;
        n_dd    = r_dd;
        n_dcnt  = r_dcnt;
        n_dnq   = r_dnq;
        n_dnr   = r_dnr;
        n_ov    = r_ov && i_out_stall;
        n_out   = r_out;
        s_we    = 1'b0;
        s_waddr = AW'(r_sp);
        s_wdata = {push_tag, i_in_data.symbol_value};
        s_raddr = AW'(sp_m2);
        l_we    = 1'b0;
        l_waddr = LAW'(r_lp);
        l_wdata = LS_NONE;
        l_raddr = LAW'(r_lp - LPW'(2));
        o_in_stall = (r_state != S_IDLE);

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op    = OP_NONE;
                    n_ev    = 1'b0;
                    n_ec    = 8'd0;
                    n_sv    = 1'b0;
                    n_st    = ST_OK;
                    n_final = 1'b1;
                    n_n     = '0;
                    n_state = S_EMIT;
                    if (in_skip) begin
                        n_st = ST_SKIP;
                    end else if (r_sp >= SPW'(STACK_DEPTH)) begin
                        n_st = ST_OVFL;
                    end else begin
                        s_we = 1'b1;
                        n_sp = r_sp + SPW'(1);
                        n_tv = i_in_data.symbol_value;
                        n_tt = push_tag;
                        if (i_in_data.symbol_tag == IN_WORD) begin
                            n_state = S_CHK;
                        end
                    end
                end
            end
            S_CHK: begin
                if (!cont) begin
                    n_state = S_EMIT;
                end else if (r_tv[31]) begin
                    n_st    = ST_INVALID;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                // drop the word, fetch the new top
                n_sp    = sp_m1;
                n_id    = r_tv[4:0];
                n_n     = r_n + NW'(1);
                s_raddr = AW'(sp_m2);
                n_state = S_RD1;
            end
            S_RD1: begin
                n_t     = s_rdata;
                s_raddr = AW'(sp_m2);
                n_state = S_RD2;
            end
            S_RD2: begin
                n_s     = s_rdata;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_tv    = t_val;
                n_tt    = t_tag;
                n_st    = ST_OK;
                n_op    = r_id;
                n_ev    = 1'b0;
                n_ec    = 8'd0;
                n_sv    = 1'b0;
                n_final = 1'b0;
                n_state = S_EMIT;
                s_wdata = {ENT_INT, bin_res};
                s_waddr = AW'(sp_m2);
                unique case (r_id)
                    OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_XOR,
                    OP_LT, OP_LE, OP_GE, OP_GT: begin
                        if (!two_int) begin
                            n_st = ST_TYPE;
                        end else begin
                            s_we = 1'b1;
                            n_sp = sp_m1;
                            n_tv = bin_res;
                            n_tt = ENT_INT;
                        end
                    end
                    OP_EQ, OP_NE: begin
                        if (r_sp < SPW'(2)) begin
                            n_st = ST_TYPE;
                        end else begin
                            s_we = 1'b1;
                            n_sp = sp_m1;
                            n_tv = bin_res;
                            n_tt = ENT_INT;
                        end
                    end
                    OP_DIV, OP_MOD: begin
                        if (!two_int) begin
                            n_st = ST_TYPE;
                        end else if (t_val == 32'd0) begin
                            n_st = ST_DIVZ;
                        end else if ((r_id == OP_DIV) && (s_val == 32'h8000_0000) &&
                                     (t_val == 32'hFFFF_FFFF)) begin
                            n_st = ST_OVFL;
                        end else begin
                            n_dq    = s_val[31] ? -s_val : s_val;
                            n_dd    = t_val[31] ? -t_val : t_val;
                            n_dr    = '0;
                            n_dcnt  = '0;
                            n_dnq   = s_val[31] ^ t_val[31];
                            n_dnr   = s_val[31];
                            n_state = S_DIV;
                        end
                    end
                    OP_NOT: begin
                        if (!top_int) begin
                            n_st = ST_TYPE;
                        end else begin
                            s_we    = 1'b1;
                            s_waddr = AW'(sp_m1);
                            s_wdata = {ENT_INT, ~t_val};
                            n_tv    = ~t_val;
                        end
                    end
                    OP_GET: begin
                        if (!top_int) begin
                            n_st = ST_TYPE;
                        end else if (t_val[31] || get_idx[33]) begin
                            n_st = ST_FRAME;
                        end else begin
                            s_raddr = get_idx[AW-1:0];
                            n_state = S_GETW;
                        end
                    end
                    OP_SET: begin
                        if (!((r_sp >= SPW'(2)) && (t_tag == ENT_INT))) begin
                            n_st = ST_TYPE;
                        end else if (t_val[31] || set_idx[33]) begin
                            n_st = ST_FRAME;
                        end else begin
                            s_we    = 1'b1;
                            s_waddr = set_idx[AW-1:0];
                            s_wdata = r_s;
                            n_sp    = sp_m2;
                            n_state = S_REFILL;
                        end
                    end
                    OP_POP: begin
                        if (r_sp == '0) begin
                            n_st = ST_TYPE;
                        end else begin
                            n_sp = sp_m1;
                            n_tv = s_val;
                            n_tt = s_tag;
                        end
                    end
                    OP_PRINT: begin
                        if (!top_int) begin
                            n_st = ST_TYPE;
                        end else begin
                            n_ev = 1'b1;
                            n_ec = t_val[7:0];
                        end
                    end
                    OP_SHOW: begin
                        if (r_sp == '0) begin
                            n_st = ST_TYPE;
                        end else begin
                            n_sv = 1'b1;
                        end
                    end
                    OP_IF: begin
                        if ((r_ltop == LS_SKIP) || (r_ltop == LS_NESTED)) begin
                            if (r_lp >= LPW'(LOGIC_DEPTH)) begin
                                n_st = ST_LOGIC_FULL;
                            end else begin
                                l_we    = 1'b1;
                                l_wdata = LS_NESTED;
                                n_lp    = r_lp + LPW'(1);
                                n_ltop  = LS_NESTED;
                            end
                        end else if (!top_int) begin
                            n_st = ST_TYPE;
                        end else if (r_lp >= LPW'(LOGIC_DEPTH)) begin
                            n_st = ST_LOGIC_FULL;
                        end else begin
                            l_we    = 1'b1;
                            l_wdata = (t_val != 32'd0) ? LS_TAKEN : LS_SKIP;
                            n_lp    = r_lp + LPW'(1);
                            n_ltop  = (t_val != 32'd0) ? LS_TAKEN : LS_SKIP;
                            n_sp    = sp_m1;
                            n_tv    = s_val;
                            n_tt    = s_tag;
                        end
                    end
                    OP_ELSE: begin
                        l_waddr = LAW'(r_lp - LPW'(1));
                        if (r_ltop == LS_NONE) begin
                            n_st = ST_LOGIC;
                        end else if (r_ltop == LS_TAKEN) begin
                            l_we    = 1'b1;
                            l_wdata = LS_SKIP;
                            n_ltop  = LS_SKIP;
                        end else if (r_ltop == LS_SKIP) begin
                            l_we    = 1'b1;
                            l_wdata = LS_TAKEN;
                            n_ltop  = LS_TAKEN;
                        end
                    end
                    OP_THEN: begin
                        if (r_ltop == LS_NONE) begin
                            n_st = ST_LOGIC;
                        end else begin
                            n_lp    = r_lp - LPW'(1);
                            n_state = S_LLOAD;
                        end
                    end
                    OP_EXEC: begin
                        if (!((r_sp != '0) && (t_tag == ENT_LIT))) begin
                            n_st = ST_TYPE;
                        end else begin
                            s_we    = 1'b1;
                            s_waddr = AW'(sp_m1);
                            s_wdata = {ENT_WORD, t_val};
                            n_tt    = ENT_WORD;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_DIV: begin
                if (!rem_diff[32]) begin
                    n_dr = rem_diff;
                    n_dq = {r_dq[30:0], 1'b1};
                end else begin
                    n_dr = rem_sh;
                    n_dq = {r_dq[30:0], 1'b0};
                end
                n_dcnt = r_dcnt + 5'd1;
                if (r_dcnt == 5'd31) begin
                    n_state = S_DIVW;
                end
            end
            S_DIVW: begin
                s_we    = 1'b1;
                s_waddr = AW'(sp_m2);
                s_wdata = {ENT_INT, div_res};
                n_sp    = sp_m1;
                n_tv    = div_res;
                n_tt    = ENT_INT;
                n_state = S_EMIT;
            end
            S_GETW: begin
                s_we    = 1'b1;
                s_waddr = AW'(sp_m1);
                s_wdata = s_rdata;
                n_tv    = s_rdata[31:0];
                n_tt    = s_rdata[33:32];
                n_state = S_EMIT;
            end
            S_REFILL: begin
                // frame write landed last cycle, now fetch the new top
                s_raddr = AW'(sp_m1);
                n_state = S_LOADTOP;
            end
            S_LOADTOP: begin
                n_tv    = s_rdata[31:0];
                n_tt    = s_rdata[33:32];
                n_state = S_EMIT;
            end
            S_LLOAD: begin
                // entry zero is never written, so it is taken as none instead of read
                n_ltop  = (r_lp == LPW'(1)) ? LS_NONE : l_rdata;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    n_ov                  = 1'b1;
                    n_out.status          = (!r_final && cont && at_limit) ? ST_CHAIN : r_st;
                    n_out.executed_op     = r_op;
                    n_out.emit_char_valid = r_ev;
                    n_out.emit_char       = r_ec;
                    n_out.show_valid      = r_sv;
                    n_out.top_value       = (r_sp != '0) ? r_tv : 32'sd0;
                    n_out.top_tag         = (r_sp != '0) ? r_tt : ENT_EMPTY;
                    n_out.stack_depth     = 9'(r_sp);
                    n_out.logic_state     = r_ltop;
                    n_out.last            = emit_last;
                    if (emit_last) begin
                        n_state = S_IDLE;
                    end else if (r_tv[31]) begin
                        // negative id on top ends the chain with its own transaction
                        n_st    = ST_INVALID;
                        n_op    = OP_NONE;
                        n_ev    = 1'b0;
                        n_ec    = 8'd0;
                        n_sv    = 1'b0;
                        n_final = 1'b1;
                    end else begin
                        n_state = S_STEP;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sp    <= '0;
            r_lp    <= LPW'(1);
            r_ltop  <= LS_NONE;
            r_n     <= '0;
            r_final <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            r_lp    <= n_lp;
            r_ltop  <= n_ltop;
            r_n     <= n_n;
            r_final <= n_final;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tv   <= n_tv;
        r_tt   <= n_tt;
        r_id   <= n_id;
        r_t    <= n_t;
        r_s    <= n_s;
        r_st   <= n_st;
        r_op   <= n_op;
        r_ev   <= n_ev;
        r_ec   <= n_ec;
        r_sv   <= n_sv;
        r_dq   <= n_dq;
        r_dr   <= n_dr;
        r_dd   <= n_dd;
        r_dcnt <= n_dcnt;
        r_dnq  <= n_dnq;
        r_dnr  <= n_dnr;
        r_out  <= n_out;
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

    a_sp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SPW'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_lp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lp >= LPW'(1)) && (r_lp <= LPW'(LOGIC_DEPTH)))
        else $error("conditional pointer out of range");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted transaction left the sequencer idle");

    a_emit_print: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.emit_char_valid) |-> (r_out.executed_op == OP_PRINT))
        else $error("character emitted by a primitive other than print");

    a_skip_noop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_out.status == ST_SKIP)) |-> (r_out.last && (r_out.executed_op == OP_NONE)))
        else $error("skipped transaction reported an executed primitive");

endmodule
`default_nettype wire
